// File: src/clpi_pkg.sv
// ----------------------------------------------------------------------------
// clpi_pkg
// Shared types and constants for the cable length PI set-point block.
// ----------------------------------------------------------------------------
package clpi_pkg;

    // Motor table
    localparam int MOTORS  = 8;
    localparam int MOTOR_W = 3;

    // Serial multiplier geometry: multiplicand, multiplier, product
    localparam int MUL_A_W = 35;
    localparam int MUL_B_W = 32;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // Width of the exact intermediate sums (integrator and set point)
    localparam int ACC_W = 52;

    // Meters per encoder tick in Q48, encoder ticks per Q8.24 LSB in Q30
    localparam logic [MUL_B_W-1:0] MPT_Q48 = 32'd134421206;
    localparam logic [MUL_B_W-1:0] TPL_Q30 = 32'd134014558;

    // Integrator clamp after reset, 0.01 m in Q8.24
    localparam logic [30:0] LIMIT_RESET = 31'd167772;

    // Set-point saturation values
    localparam logic signed [31:0] SP_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] SP_MIN = 32'sh8000_0000;

    // Configuration register indexes
    typedef logic [1:0] cfg_index_t;
    localparam cfg_index_t CFG_PROP_GAIN   = 2'd0;
    localparam cfg_index_t CFG_INTEG_GAIN  = 2'd1;
    localparam cfg_index_t CFG_INTEG_LIMIT = 2'd2;

    // Item kinds
    localparam logic KIND_CONTROL   = 1'b0;
    localparam logic KIND_CALIBRATE = 1'b1;

    typedef struct packed {
        logic signed [31:0] prop_gain;
        logic signed [31:0] integ_gain;
        logic [30:0]        integ_limit;
    } cfg_t;

    typedef struct packed {
        logic [MOTOR_W-1:0] motor_out;
        logic signed [31:0] setpoint_ticks;
        logic               saturated;
    } result_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CAL_MUL,
        ST_CAL_SIGN,
        ST_CAL_WR,
        ST_ERR,
        ST_INT_START,
        ST_INT_MUL,
        ST_INT_ADD,
        ST_INT_CLAMP,
        ST_SUM_I,
        ST_PROP_MUL,
        ST_PROP_ADD,
        ST_RANGE,
        ST_TICK_MUL,
        ST_TICK_FIN,
        ST_DONE
    } core_state_t;

endpackage

// File: src/clpi_if.sv
// ----------------------------------------------------------------------------
// clpi channel interfaces
// Valid/ready channels for command items, result items and register writes.
// ----------------------------------------------------------------------------
interface clpi_cmd_if;
    logic                        valid;
    logic                        ready;
    logic                        kind;
    logic [clpi_pkg::MOTOR_W-1:0] motor;
    logic signed [31:0]          cable_length;
    logic signed [31:0]          target_length;
    logic signed [31:0]          encoder_ticks;

    modport source (
        output valid, kind, motor, cable_length, target_length, encoder_ticks,
        input  ready
    );
    modport sink (
        input  valid, kind, motor, cable_length, target_length, encoder_ticks,
        output ready
    );
endinterface

interface clpi_res_if;
    logic                        valid;
    logic                        ready;
    logic [clpi_pkg::MOTOR_W-1:0] motor_out;
    logic signed [31:0]          setpoint_ticks;
    logic                        saturated;

    modport source (
        output valid, motor_out, setpoint_ticks, saturated,
        input  ready
    );
    modport sink (
        input  valid, motor_out, setpoint_ticks, saturated,
        output ready
    );
endinterface

interface clpi_cfg_if;
    logic                 valid;
    logic                 ready;
    clpi_pkg::cfg_index_t index;
    logic [31:0]          data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

// File: src/clpi_sermul.sv
// ----------------------------------------------------------------------------
// clpi_sermul
// Unsigned shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module clpi_sermul (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [clpi_pkg::MUL_A_W-1:0]  a,
    input  logic [clpi_pkg::MUL_B_W-1:0]  b,
    output logic                          done,
    output logic [clpi_pkg::MUL_P_W-1:0]  prod
);

    localparam int CNT_W = $clog2(clpi_pkg::MUL_B_W);

    logic                         busy_reg, busy_next;
    logic                         done_reg, done_next;
    logic [CNT_W-1:0]             cnt_reg, cnt_next;
    logic [clpi_pkg::MUL_A_W-1:0] a_reg, a_next;
    logic [clpi_pkg::MUL_A_W-1:0] hi_reg, hi_next;
    logic [clpi_pkg::MUL_B_W-1:0] lo_reg, lo_next;
    logic [clpi_pkg::MUL_A_W:0]   step_sum;

    // partial sum of this step, carry kept
    assign step_sum = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, a_reg} : '0);

    // next state of the shift pair
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        hi_next   = hi_reg;
        lo_next   = lo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(clpi_pkg::MUL_B_W - 1);
            a_next    = a;
            hi_next   = '0;
            lo_next   = b;
        end
        else if (busy_reg)
        begin
            hi_next  = step_sum[clpi_pkg::MUL_A_W:1];
            lo_next  = {step_sum[0], lo_reg[clpi_pkg::MUL_B_W-1:1]};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // operands and product
    always_ff @(posedge clk)
    begin
        a_reg  <= a_next;
        hi_reg <= hi_next;
        lo_reg <= lo_next;
    end

    assign done = done_reg;
    assign prod = {hi_reg, lo_reg};

endmodule

// File: src/clpi_core.sv
// ----------------------------------------------------------------------------
// clpi_core
// Sequencer, per-motor state and narrow datapath around the serial multiplier.
// ----------------------------------------------------------------------------
module clpi_core (
    input  logic              clk,
    input  logic              rst_n,
    clpi_cmd_if.sink          cmd,
    input  clpi_pkg::cfg_t    cfg,
    output clpi_pkg::result_t res,
    output logic              res_valid,
    input  logic              res_ready
);

    localparam int ACC_W = clpi_pkg::ACC_W;
    localparam int P_W   = clpi_pkg::MUL_P_W;

    // magnitude helpers, two's complement in, unsigned out
    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        return v[31] ? 32'(-v) : 32'(v);
    endfunction

    function automatic logic [32:0] mag33(input logic signed [32:0] v);
        return v[32] ? 33'(-v) : 33'(v);
    endfunction

    function automatic logic [ACC_W-1:0] mag_acc(input logic signed [ACC_W-1:0] v);
        return v[ACC_W-1] ? ACC_W'(-v) : ACC_W'(v);
    endfunction

    clpi_pkg::core_state_t state_reg, state_next;

    logic [clpi_pkg::MOTOR_W-1:0] motor_reg, motor_next;
    logic signed [31:0]           len_reg, len_next;
    logic signed [31:0]           tgt_reg, tgt_next;
    logic                         neg_reg, neg_next;
    logic signed [32:0]           err_reg, err_next;
    logic signed [ACC_W-1:0]      acc_reg, acc_next;
    logic signed [ACC_W-1:0]      sum_reg, sum_next;
    logic signed [31:0]           integ_reg, integ_next;
    clpi_pkg::result_t            res_reg, res_next;

    // per-motor state
    logic signed [31:0]           integrator_reg [clpi_pkg::MOTORS];
    logic signed [31:0]           offset_reg     [clpi_pkg::MOTORS];
    logic [clpi_pkg::MOTORS-1:0]  calibrated_reg;
    logic                         integ_we;
    logic                         cal_we;
    logic signed [31:0]           offset_wdata;

    // multiplier port
    logic                         mul_start;
    logic [clpi_pkg::MUL_A_W-1:0] mul_a;
    logic [clpi_pkg::MUL_B_W-1:0] mul_b;
    logic                         mul_done;
    logic [P_W-1:0]               mul_prod;

    // datapath terms
    logic signed [ACC_W-1:0]      prod_q16;
    logic signed [ACC_W-1:0]      prod_q24;
    logic [36:0]                  prod_q30;
    logic signed [ACC_W-1:0]      integ_cur;
    logic signed [ACC_W-1:0]      lim_pos;
    logic signed [ACC_W-1:0]      lim_neg;
    logic signed [ACC_W-1:0]      cal_diff;
    logic [ACC_W-1:0]             sum_mag;

    clpi_sermul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    // product views after the fixed-point shifts
    assign prod_q16  = $signed(ACC_W'(mul_prod[P_W-1:16]));
    assign prod_q24  = $signed(ACC_W'(mul_prod[P_W-1:24]));
    assign prod_q30  = mul_prod[P_W-1:30];
    assign integ_cur = ACC_W'(integrator_reg[motor_reg]);
    assign lim_pos   = $signed(ACC_W'(cfg.integ_limit));
    assign lim_neg   = -lim_pos;
    assign cal_diff  = sum_reg - ACC_W'(len_reg);
    assign sum_mag   = mag_acc(sum_reg);

    // sequencer and datapath
    always_comb
    begin
        state_next   = state_reg;
        motor_next   = motor_reg;
        len_next     = len_reg;
        tgt_next     = tgt_reg;
        neg_next     = neg_reg;
        err_next     = err_reg;
        acc_next     = acc_reg;
        sum_next     = sum_reg;
        integ_next   = integ_reg;
        res_next     = res_reg;
        integ_we     = 1'b0;
        cal_we       = 1'b0;
        offset_wdata = cal_diff[31:0];
        mul_start    = 1'b0;
        mul_a        = '0;
        mul_b        = '0;
        cmd.ready    = (state_reg == clpi_pkg::ST_IDLE);
        res_valid    = (state_reg == clpi_pkg::ST_DONE);

        case (state_reg)
            clpi_pkg::ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    motor_next = cmd.motor;
                    len_next   = cmd.cable_length;
                    tgt_next   = cmd.target_length;
                    if (cmd.kind == clpi_pkg::KIND_CALIBRATE)
                    begin
                        mul_start  = 1'b1;
                        mul_a      = clpi_pkg::MUL_A_W'(mag32(cmd.encoder_ticks));
                        mul_b      = clpi_pkg::MPT_Q48;
                        neg_next   = cmd.encoder_ticks[31];
                        state_next = clpi_pkg::ST_CAL_MUL;
                    end
                    else if (calibrated_reg[cmd.motor])
                    begin
                        state_next = clpi_pkg::ST_ERR;
                    end
                end
            end

            clpi_pkg::ST_CAL_MUL:
            begin
                if (mul_done)
                    state_next = clpi_pkg::ST_CAL_SIGN;
            end

            // encoder position in meters
            clpi_pkg::ST_CAL_SIGN:
            begin
                sum_next   = neg_reg ? -prod_q24 : prod_q24;
                state_next = clpi_pkg::ST_CAL_WR;
            end

            // offset = meters - length, saturated to 32 bit
            clpi_pkg::ST_CAL_WR:
            begin
                if (cal_diff > ACC_W'(clpi_pkg::SP_MAX))
                    offset_wdata = clpi_pkg::SP_MAX;
                else if (cal_diff < ACC_W'(clpi_pkg::SP_MIN))
                    offset_wdata = clpi_pkg::SP_MIN;
                cal_we     = 1'b1;
                state_next = clpi_pkg::ST_IDLE;
            end

            // error, and offset plus target as the start of the set point
            clpi_pkg::ST_ERR:
            begin
                err_next   = 33'(len_reg) - 33'(tgt_reg);
                sum_next   = ACC_W'(offset_reg[motor_reg]) + ACC_W'(tgt_reg);
                state_next = clpi_pkg::ST_INT_START;
            end

            clpi_pkg::ST_INT_START:
            begin
                mul_start  = 1'b1;
                mul_a      = clpi_pkg::MUL_A_W'(mag33(err_reg));
                mul_b      = mag32(cfg.integ_gain);
                neg_next   = err_reg[32] ^ cfg.integ_gain[31];
                state_next = clpi_pkg::ST_INT_MUL;
            end

            clpi_pkg::ST_INT_MUL:
            begin
                if (mul_done)
                    state_next = clpi_pkg::ST_INT_ADD;
            end

            clpi_pkg::ST_INT_ADD:
            begin
                acc_next   = neg_reg ? integ_cur - prod_q16 : integ_cur + prod_q16;
                state_next = clpi_pkg::ST_INT_CLAMP;
            end

            // clamp to the limit; a zero gain clears the integrator
            clpi_pkg::ST_INT_CLAMP:
            begin
                if (cfg.integ_gain == '0)
                    integ_next = '0;
                else if (acc_reg > lim_pos)
                    integ_next = lim_pos[31:0];
                else if (acc_reg < lim_neg)
                    integ_next = lim_neg[31:0];
                else
                    integ_next = acc_reg[31:0];
                integ_we   = 1'b1;
                state_next = clpi_pkg::ST_SUM_I;
            end

            clpi_pkg::ST_SUM_I:
            begin
                sum_next   = sum_reg + ACC_W'(integ_reg);
                mul_start  = 1'b1;
                mul_a      = clpi_pkg::MUL_A_W'(mag33(err_reg));
                mul_b      = mag32(cfg.prop_gain);
                neg_next   = err_reg[32] ^ cfg.prop_gain[31];
                state_next = clpi_pkg::ST_PROP_MUL;
            end

            clpi_pkg::ST_PROP_MUL:
            begin
                if (mul_done)
                    state_next = clpi_pkg::ST_PROP_ADD;
            end

            clpi_pkg::ST_PROP_ADD:
            begin
                sum_next   = neg_reg ? sum_reg - prod_q16 : sum_reg + prod_q16;
                state_next = clpi_pkg::ST_RANGE;
            end

            // out of the tick range: saturate without converting
            clpi_pkg::ST_RANGE:
            begin
                neg_next = sum_reg[ACC_W-1];
                res_next.motor_out = motor_reg;
                if (|sum_mag[ACC_W-1:35])
                begin
                    res_next.setpoint_ticks = sum_reg[ACC_W-1] ? clpi_pkg::SP_MIN
                                                               : clpi_pkg::SP_MAX;
                    res_next.saturated      = 1'b1;
                    state_next              = clpi_pkg::ST_DONE;
                end
                else
                begin
                    mul_start  = 1'b1;
                    mul_a      = sum_mag[clpi_pkg::MUL_A_W-1:0];
                    mul_b      = clpi_pkg::TPL_Q30;
                    state_next = clpi_pkg::ST_TICK_MUL;
                end
            end

            clpi_pkg::ST_TICK_MUL:
            begin
                if (mul_done)
                    state_next = clpi_pkg::ST_TICK_FIN;
            end

            // meters to ticks, truncated toward zero, clipped to 32 bit
            clpi_pkg::ST_TICK_FIN:
            begin
                if (!neg_reg)
                begin
                    res_next.saturated      = |prod_q30[36:31];
                    res_next.setpoint_ticks = (|prod_q30[36:31]) ? clpi_pkg::SP_MAX
                                                                 : prod_q30[31:0];
                end
                else
                begin
                    res_next.saturated      = (|prod_q30[36:32]) ||
                                              (prod_q30[31] && (|prod_q30[30:0]));
                    res_next.setpoint_ticks = res_next.saturated ? clpi_pkg::SP_MIN
                                                                 : -prod_q30[31:0];
                end
                state_next = clpi_pkg::ST_DONE;
            end

            clpi_pkg::ST_DONE:
            begin
                if (res_ready)
                    state_next = clpi_pkg::ST_IDLE;
            end

            default:
            begin
                state_next = clpi_pkg::ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= clpi_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // item payload and working registers
    always_ff @(posedge clk)
    begin
        motor_reg <= motor_next;
        len_reg   <= len_next;
        tgt_reg   <= tgt_next;
        neg_reg   <= neg_next;
        err_reg   <= err_next;
        acc_reg   <= acc_next;
        sum_reg   <= sum_next;
        integ_reg <= integ_next;
        res_reg   <= res_next;
    end

    // integrators and calibration flags, cleared by reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < clpi_pkg::MOTORS; i++)
                integrator_reg[i] <= '0;
            calibrated_reg <= '0;
        end
        else
        begin
            if (integ_we)
                integrator_reg[motor_reg] <= integ_next;
            if (cal_we)
                calibrated_reg[motor_reg] <= 1'b1;
        end
    end

    // offsets, only read once the motor is calibrated
    always_ff @(posedge clk)
    begin
        if (cal_we)
            offset_reg[motor_reg] <= offset_wdata;
    end

    assign res = res_reg;

endmodule

// File: src/cable_length_pi_setpoint.sv
// ----------------------------------------------------------------------------
// cable_length_pi_setpoint
// Per-motor PI controller turning cable lengths into encoder set points.
// ----------------------------------------------------------------------------
// Items are handled one at a time, and a control item for an uncalibrated
// motor is dropped. An item's time is set by the 32-step shift-add
// multiplier, which a control item uses three times (integral gain,
// proportional gain, meters to ticks) and a calibrate item once. A finished
// set point sits in the output register, so the next item is taken while it
// waits. Register writes are taken at any time and should only be made while
// no item is in flight.
module cable_length_pi_setpoint (
    input  logic       clk,
    input  logic       rst_n,
    clpi_cfg_if.sink   cfg,
    clpi_cmd_if.sink   cmd,
    clpi_res_if.source result
);

    clpi_pkg::cfg_t    cfg_reg, cfg_next;
    logic              res_valid_reg, res_valid_next;
    clpi_pkg::result_t res_reg, res_next;

    clpi_pkg::result_t core_res;
    logic              core_res_valid;
    logic              core_res_ready;

    clpi_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cfg       (cfg_reg),
        .res       (core_res),
        .res_valid (core_res_valid),
        .res_ready (core_res_ready)
    );

    // register writes
    assign cfg.ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                clpi_pkg::CFG_PROP_GAIN:   cfg_next.prop_gain   = cfg.data;
                clpi_pkg::CFG_INTEG_GAIN:  cfg_next.integ_gain  = cfg.data;
                clpi_pkg::CFG_INTEG_LIMIT: cfg_next.integ_limit = cfg.data[30:0];
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    // output register
    assign core_res_ready = !res_valid_reg || result.ready;

    always_comb
    begin
        res_valid_next = res_valid_reg;
        res_next       = res_reg;
        if (core_res_ready)
        begin
            res_valid_next = core_res_valid;
            if (core_res_valid)
                res_next = core_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.prop_gain   <= '0;
            cfg_reg.integ_gain  <= '0;
            cfg_reg.integ_limit <= clpi_pkg::LIMIT_RESET;
            res_valid_reg       <= 1'b0;
        end
        else
        begin
            cfg_reg       <= cfg_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign result.valid          = res_valid_reg;
    assign result.motor_out      = res_reg.motor_out;
    assign result.setpoint_ticks = res_reg.setpoint_ticks;
    assign result.saturated      = res_reg.saturated;

    // a clipped set point sits at one of the range ends
    a_sat_extreme: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.saturated) |->
        (result.setpoint_ticks == clpi_pkg::SP_MAX ||
         result.setpoint_ticks == clpi_pkg::SP_MIN))
        else $error("saturated set point not at a range end");

    // the core holds a refused result unchanged
    a_core_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (core_res_valid && !core_res_ready) |=> (core_res_valid && $stable(core_res)))
        else $error("core result dropped or changed while stalled");

    // no new item is taken while the core still offers a result
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.ready && core_res_valid))
        else $error("core ready for an item while a result is pending");

endmodule
